// ===== design/tlbr_pkg.sv =====
`default_nettype none
package tlbr_pkg;
  localparam int TLB_ENTRIES = 4;
  localparam int FRAMES = 32;
  localparam int PAGE_BITS = 7;
  localparam int SLOT_W = $clog2(TLB_ENTRIES);
  localparam int FRAME_W = $clog2(FRAMES);
  localparam int VPN_W = 25;
  localparam logic [SLOT_W:0] SLOT_NONE = (SLOT_W + 1)'(TLB_ENTRIES);

  localparam logic [2:0] ST_TABLE_HIT = 3'd0;
  localparam logic [2:0] ST_PAGE_FAULT = 3'd1;
  localparam logic [2:0] ST_ADDR_ERR = 3'd2;
  localparam logic [2:0] ST_DIRTY_MARKED = 3'd3;
  localparam logic [2:0] ST_WRITE_MISS = 3'd4;

  typedef struct packed {
    logic capture;
    logic scan;
    logic mark;
    logic evict;
    logic load;
    logic addr_err;
  } tlbr_cmd_t;

  typedef struct packed {
    logic is_write;
    logic scan_hit;
    logic scan_last;
    logic hit;
    logic out_of_space;
  } tlbr_stat_t;
endpackage
`default_nettype wire

// ===== design/tlbr_ctrl.sv =====
`default_nettype none
module tlbr_ctrl
  import tlbr_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  input  wire tlbr_stat_t stat,
  output tlbr_cmd_t       cmd,
  output logic            busy,
  output logic            done
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MARK = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_DECIDE = 3'd3;
  localparam logic [2:0] S_EVICT = 3'd4;
  localparam logic [2:0] S_LOAD = 3'd5;
  localparam logic [2:0] S_ERR = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  logic [2:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.is_write) begin
          state_next = S_MARK;
        end else begin
          cmd.scan = 1'b1;
          if (stat.scan_hit || stat.scan_last) state_next = S_DECIDE;
        end
      end
      S_MARK: begin
        cmd.mark = 1'b1;
        state_next = S_DONE;
      end
      S_DECIDE: begin
        if (stat.hit) state_next = S_LOAD;
        else if (stat.out_of_space) state_next = S_ERR;
        else state_next = S_EVICT;
      end
      S_EVICT: begin
        cmd.evict = 1'b1;
        state_next = S_LOAD;
      end
      S_LOAD: begin
        cmd.load = 1'b1;
        state_next = S_DONE;
      end
      S_ERR: begin
        cmd.addr_err = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);
endmodule
`default_nettype wire

// ===== design/tlbr_dp.sv =====
`default_nettype none
module tlbr_dp
  import tlbr_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire tlbr_cmd_t    cmd,
  input  wire logic         kind,
  input  wire logic [7:0]   proc_id,
  input  wire logic [31:0]  vaddr,
  input  wire logic [25:0]  space_pages,
  input  wire logic [31:0]  now_ticks,
  output tlbr_stat_t        stat,
  output logic [2:0]        status,
  output logic [4:0]        frame,
  output logic [1:0]        tlb_slot,
  output logic              page_out_needed,
  output logic [7:0]        victim_proc,
  output logic [VPN_W-1:0]  victim_page
);
  logic [VPN_W-1:0]   tlb_page [TLB_ENTRIES];
  logic [FRAME_W-1:0] tlb_frame [TLB_ENTRIES];
  logic [TLB_ENTRIES-1:0] tlb_valid, tlb_dirty;
  logic [SLOT_W-1:0]  fifo_next;
  logic [FRAMES-1:0]  frame_valid, frame_dirty;
  logic [7:0]         frame_owner [FRAMES];
  logic [VPN_W-1:0]   frame_page [FRAMES];
  logic [SLOT_W:0]    frame_slot [FRAMES];
  logic [31:0]        frame_last_use [FRAMES];

  logic               is_write;
  logic [7:0]         pid;
  logic [VPN_W-1:0]   page;
  logic [25:0]        space;
  logic [31:0]        now;
  logic [FRAME_W-1:0] idx;
  logic               hit, inv_found;
  logic [FRAME_W-1:0] hit_frame, inv_idx, best_idx;
  logic [31:0]        best_use;

  logic               scan_hit;
  logic               mark_found;
  logic [SLOT_W-1:0]  mark_slot;
  logic               free_found;
  logic [SLOT_W-1:0]  free_slot, load_slot;
  logic [FRAME_W-1:0] victim, load_frame, old_frame;
  logic               old_valid, load_dirty;
  logic [SLOT_W:0]    vslot;

  assign scan_hit = frame_valid[idx] && (frame_owner[idx] == pid) && (frame_page[idx] == page);
  assign victim = inv_found ? inv_idx : best_idx;
  assign load_frame = hit ? hit_frame : victim;
  assign vslot = frame_slot[victim];

  always_comb begin
    mark_found = 1'b0;
    mark_slot = '0;
    free_found = 1'b0;
    free_slot = '0;
    for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
      if (tlb_valid[i] && tlb_page[i] == page) begin
        mark_found = 1'b1;
        mark_slot = SLOT_W'(i);
      end
      if (!tlb_valid[i]) begin
        free_found = 1'b1;
        free_slot = SLOT_W'(i);
      end
    end
  end

  assign load_slot = free_found ? free_slot : fifo_next;
  assign old_frame = tlb_frame[load_slot];
  assign old_valid = tlb_valid[load_slot];
  assign load_dirty = (old_valid && old_frame == load_frame) ? tlb_dirty[load_slot]
                                                             : frame_dirty[load_frame];

  assign stat.is_write = is_write;
  assign stat.scan_hit = scan_hit;
  assign stat.scan_last = (idx == FRAME_W'(FRAMES - 1));
  assign stat.hit = hit;
  assign stat.out_of_space = ({1'b0, page} >= space);

  always_ff @(posedge clk) begin
    if (rst) begin
      tlb_valid <= '0;
      tlb_dirty <= '0;
      fifo_next <= '0;
      frame_valid <= '0;
      frame_dirty <= '0;
      for (int i = 0; i < TLB_ENTRIES; i++) begin
        tlb_page[i] <= '0;
        tlb_frame[i] <= '0;
      end
      for (int i = 0; i < FRAMES; i++) begin
        frame_slot[i] <= SLOT_NONE;
        frame_last_use[i] <= '0;
      end
    end else begin
      if (cmd.capture) begin
        is_write <= kind;
        pid <= proc_id;
        page <= vaddr[PAGE_BITS +: VPN_W];
        space <= space_pages;
        now <= now_ticks;
        idx <= '0;
        hit <= 1'b0;
        inv_found <= 1'b0;
        frame <= '0;
        tlb_slot <= '0;
        page_out_needed <= 1'b0;
        victim_proc <= '0;
        victim_page <= '0;
      end
      if (cmd.scan) begin
        idx <= idx + 1'b1;
        if (scan_hit) begin
          hit <= 1'b1;
          hit_frame <= idx;
        end
        if (!frame_valid[idx] && !inv_found) begin
          inv_found <= 1'b1;
          inv_idx <= idx;
        end
        if (idx == '0 || frame_last_use[idx] < best_use) begin
          best_idx <= idx;
          best_use <= frame_last_use[idx];
        end
      end
      if (cmd.mark) begin
        if (mark_found) begin
          tlb_dirty[mark_slot] <= 1'b1;
          status <= ST_DIRTY_MARKED;
          tlb_slot <= mark_slot;
          frame <= tlb_frame[mark_slot];
        end else begin
          status <= ST_WRITE_MISS;
        end
      end
      if (cmd.addr_err) begin
        status <= ST_ADDR_ERR;
      end
      if (cmd.evict) begin
        if (frame_valid[victim]) begin
          if (!vslot[SLOT_W]) begin
            tlb_valid[vslot[SLOT_W-1:0]] <= 1'b0;
            page_out_needed <= tlb_dirty[vslot[SLOT_W-1:0]];
          end else begin
            page_out_needed <= frame_dirty[victim];
          end
          victim_proc <= frame_owner[victim];
          victim_page <= frame_page[victim];
        end
        frame_valid[victim] <= 1'b1;
        frame_owner[victim] <= pid;
        frame_page[victim] <= page;
        frame_dirty[victim] <= 1'b0;
        frame_slot[victim] <= SLOT_NONE;
      end
      if (cmd.load) begin
        fifo_next <= load_slot + 1'b1;
        if (old_valid) begin
          frame_dirty[old_frame] <= tlb_dirty[load_slot];
        end
        if (old_valid && old_frame != load_frame) begin
          frame_slot[old_frame] <= SLOT_NONE;
        end
        tlb_page[load_slot] <= page;
        tlb_frame[load_slot] <= load_frame;
        tlb_valid[load_slot] <= 1'b1;
        tlb_dirty[load_slot] <= load_dirty;
        frame_slot[load_frame] <= {1'b0, load_slot};
        frame_last_use[load_frame] <= now;
        status <= hit ? ST_TABLE_HIT : ST_PAGE_FAULT;
        frame <= load_frame;
        tlb_slot <= load_slot;
      end
    end
  end
endmodule
`default_nettype wire

// ===== design/tlb_refill_fifo_ipt_lru.sv =====
// channel   | signals                                            | transfer
// ----------+----------------------------------------------------+----------------------
// request   | kind proc_id vaddr space_pages now_ticks          | start high, busy low
// result    | status frame tlb_slot page_out_needed victim_proc  | done high, one cycle
//           | victim_page                                        |
// a write item goes from transfer through the scan and mark states to done
// a refill scans the frame table one frame a cycle; a table hit ends the scan
// at the owning frame
// busy stays high until done; done can't be held off by the receiver
// synchronous reset clears the tlb and the frame-valid, dirty, slot and last-use state
`default_nettype none
module tlb_refill_fifo_ipt_lru
  import tlbr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        kind,
  input  wire logic [7:0]  proc_id,
  input  wire logic [31:0] vaddr,
  input  wire logic [25:0] space_pages,
  input  wire logic [31:0] now_ticks,
  output logic             done,
  output logic [2:0]       status,
  output logic [4:0]       frame,
  output logic [1:0]       tlb_slot,
  output logic             page_out_needed,
  output logic [7:0]       victim_proc,
  output logic [24:0]      victim_page
);
  tlbr_cmd_t  cmd;
  tlbr_stat_t stat;

  tlbr_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .stat(stat),
    .cmd(cmd), .busy(busy), .done(done)
  );

  tlbr_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd),
    .kind(kind), .proc_id(proc_id), .vaddr(vaddr),
    .space_pages(space_pages), .now_ticks(now_ticks),
    .stat(stat), .status(status), .frame(frame), .tlb_slot(tlb_slot),
    .page_out_needed(page_out_needed), .victim_proc(victim_proc),
    .victim_page(victim_page)
  );
endmodule
`default_nettype wire
